/* hw/rtl/shabs_pkg.sv */
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by shabs_compress, the top level and the port checker; depends on nothing.
package shabs_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	// Control from the top level sequencer to the compression unit.
	typedef struct packed {
		logic start;
		logic reinit;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sts_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] v);
		return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] v);
		return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] v);
		return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] v);
		return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
	endfunction

endpackage

/* hw/rtl/sha256_byte_stream_hasher_core.sv */
// SHA-256 byte stream hasher: one byte per request, eight digest words per message.
// The 64th byte of a block starts a compression.
// Finishing writes the padding one byte per cycle, runs one or two compressions and then
// presents the eight digest words, one per cycle while taken.
// Sustained rate is set by the single round unit: no byte is taken while a block is compressed.
// Reset clears the counters and sequencer and loads the initial hash values.
module sha256_byte_stream_hasher_core import shabs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_ready,
	input  msg_t msg,
	output logic dig_valid,
	input  logic dig_ready,
	output dig_t dig
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BLK  = 3'd1;
	localparam logic [2:0] ST_P80  = 3'd2;
	localparam logic [2:0] ST_Z1   = 3'd3;
	localparam logic [2:0] ST_C1   = 3'd4;
	localparam logic [2:0] ST_Z2   = 3'd5;
	localparam logic [2:0] ST_C2   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LEN_POS  = 6'd56;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [5:0]  ptr_q;
	logic [60:0] byte_cnt_q;
	logic        eom_q;
	logic [2:0]  oidx_q;
	dig_t        out_q;
	logic        out_valid_q;

	ctl_t        ctl;
	sts_t        sts;
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_byte;
	logic [31:0] h_word;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic        acc, load;

	assign msg_ready = (state_q == ST_IDLE);
	assign acc       = msg_valid && msg_ready;
	assign load      = (state_q == ST_OUT) && (!out_valid_q || dig_ready);
	assign bit_len   = {byte_cnt_q, 3'b000};
	assign len_byte  = bit_len[{~ptr_q[2:0], 3'b000} +: 8];
	assign dig_valid = out_valid_q;
	assign dig       = out_q;

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = fill_q;
		wr_byte    = msg.data_byte;
		ctl.start  = 1'b0;
		ctl.reinit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				wr_en     = acc && msg.byte_valid;
				ctl.start = acc && msg.byte_valid && (fill_q == LAST_POS);
			end
			ST_P80: begin
				wr_en     = 1'b1;
				wr_byte   = PAD_BYTE;
				ctl.start = (fill_q == LAST_POS);
			end
			ST_Z1: begin
				wr_en     = 1'b1;
				wr_addr   = ptr_q;
				wr_byte   = 8'h00;
				ctl.start = (ptr_q == LAST_POS);
			end
			ST_Z2: begin
				// The last eight bytes of the final block carry the bit length.
				wr_en     = 1'b1;
				wr_addr   = ptr_q;
				wr_byte   = (ptr_q >= LEN_POS) ? len_byte : 8'h00;
				ctl.start = (ptr_q == LAST_POS);
			end
			ST_OUT: begin
				ctl.reinit = load && (oidx_q == 3'd7);
			end
			default: begin
			end
		endcase
	end

	shabs_compress u_comp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_byte (wr_byte),
		.rd_idx  (oidx_q),
		.h_word  (h_word),
		.sts     (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			ptr_q      <= '0;
			byte_cnt_q <= '0;
			eom_q      <= 1'b0;
			oidx_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (msg.byte_valid) begin
							fill_q     <= fill_q + 6'd1;
							byte_cnt_q <= byte_cnt_q + 61'd1;
						end
						if (msg.byte_valid && (fill_q == LAST_POS)) begin
							eom_q   <= msg.end_of_message;
							state_q <= ST_BLK;
						end else if (msg.end_of_message) begin
							state_q <= ST_P80;
						end
					end
				end
				ST_BLK: begin
					if (sts.done) begin
						state_q <= eom_q ? ST_P80 : ST_IDLE;
					end
				end
				ST_P80: begin
					ptr_q <= fill_q + 6'd1;
					if (fill_q == LAST_POS) begin
						state_q <= ST_C1;
					end else if (fill_q >= LEN_POS) begin
						state_q <= ST_Z1;
					end else begin
						state_q <= ST_Z2;
					end
				end
				ST_Z1: begin
					if (ptr_q == LAST_POS) begin
						state_q <= ST_C1;
					end else begin
						ptr_q <= ptr_q + 6'd1;
					end
				end
				ST_C1: begin
					if (sts.done) begin
						ptr_q   <= '0;
						state_q <= ST_Z2;
					end
				end
				ST_Z2: begin
					if (ptr_q == LAST_POS) begin
						state_q <= ST_C2;
					end else begin
						ptr_q <= ptr_q + 6'd1;
					end
				end
				ST_C2: begin
					if (sts.done) begin
						oidx_q     <= '0;
						fill_q     <= '0;
						byte_cnt_q <= '0;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (dig_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.digest_word <= h_word;
			out_q.word_index  <= oidx_q;
			out_q.last_word   <= (oidx_q == 3'd7);
		end
	end

endmodule

/* hw/rtl/shabs_compress.sv */
// Block buffer and iterative SHA-256 compression unit, one round per cycle.
// Holds the chaining words; depends on shabs_pkg.
module shabs_compress import shabs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic        wr_en,
	input  logic [5:0]  wr_addr,
	input  logic [7:0]  wr_byte,
	input  logic [2:0]  rd_idx,
	output logic [31:0] h_word,
	output sts_t        sts
);

	localparam logic [6:0] CNT_LAST = 7'd66;

	logic [31:0] mem_q [16];
	logic [31:0] rdata_q;
	logic [31:0] win_q [16];
	logic [31:0] w_q;
	logic [31:0] s_q [8];
	logic [31:0] h_q [8];
	logic [6:0]  cnt_q;
	logic        busy_q;

	logic [31:0] sched, w_new, t1, t2, ch, maj;
	logic [6:0]  t_full;
	logic [5:0]  t_idx;
	logic        sched_en, round_en, done;

	// Bytes are stored big endian within each 32-bit word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
		end
		rdata_q <= mem_q[cnt_q[3:0]];
	end

	always_comb begin
		sched    = win_q[0] + small_sig0(win_q[1]) + win_q[9] + small_sig1(win_q[14]);
		w_new    = (cnt_q <= 7'd16) ? rdata_q : sched;
		t_full   = cnt_q - 7'd2;
		t_idx    = t_full[5:0];
		ch       = (s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]);
		maj      = (s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]);
		t1       = s_q[7] + big_sig1(s_q[4]) + ch + K_TAB[t_idx] + w_q;
		t2       = big_sig0(s_q[0]) + maj;
		sched_en = busy_q && (cnt_q >= 7'd1) && (cnt_q <= 7'd64);
		round_en = busy_q && (cnt_q >= 7'd2) && (cnt_q <= 7'd65);
		done     = busy_q && (cnt_q == CNT_LAST);
	end

	assign h_word   = h_q[rd_idx];
	assign sts.busy = busy_q;
	assign sts.done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			h_q    <= IV_TAB;
		end else begin
			if (ctl.reinit) begin
				h_q <= IV_TAB;
			end
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (done) begin
					busy_q <= 1'b0;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + s_q[i];
					end
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
		end
	end

	// Word t of the schedule is registered in the cycle before round t.
	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			s_q <= h_q;
		end else if (round_en) begin
			s_q[7] <= s_q[6];
			s_q[6] <= s_q[5];
			s_q[5] <= s_q[4];
			s_q[4] <= s_q[3] + t1;
			s_q[3] <= s_q[2];
			s_q[2] <= s_q[1];
			s_q[1] <= s_q[0];
			s_q[0] <= t1 + t2;
		end
		if (sched_en) begin
			w_q <= w_new;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
		end
	end

endmodule

/* hw/rtl/shabs_checker.sv */
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on shabs_pkg and sha256_byte_stream_hasher_core.
module shabs_checker import shabs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic msg_valid,
	input logic msg_ready,
	input msg_t msg,
	input logic dig_valid,
	input logic dig_ready,
	input dig_t dig
);

	// A stalled digest word keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig))
	else $error("digest word changed while stalled");

	// No new request is taken while a digest is only partly delivered.
	assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig.last_word |-> !msg_ready)
	else $error("request accepted during digest output");

	// Finishing a message always makes the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg.end_of_message |=> !msg_ready)
	else $error("ready after end of message");

	// A digest starts at its most significant word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> dig.word_index == 3'd0)
	else $error("digest did not start at word zero");

endmodule

bind sha256_byte_stream_hasher_core shabs_checker u_shabs_checker (.*);
